// ===== src/orlb_pkg.sv =====
// ----------------------------------------------------------------------------
// orlb_pkg
// Shared types and constants for the overwriting circular log buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package orlb_pkg;

   localparam int DEPTH_DEF        = 64;
   localparam int PAYLOAD_BITS_DEF = 64;
   localparam int SEQ_W            = 64;
   localparam int TOTAL_W          = 32;
   localparam int ACTION_W         = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_SEEK  = 3'd3,
      ACT_PROBE = 3'd4,
      ACT_CLEAR = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_OLD_RD,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/overwrite_ring_log_buffer_core.sv =====
// Push, pop, peek, clear and unknown actions pass the execute, oldest-read and done states
// after the transfer in; seek and probe add a memory walk over at most the occupied entries,
// one entry read per cycle from the single read port of the entry memories.
// A new request is taken once the previous one leaves the done state, which waits for a free
// output register, also while the previous result still waits in the output register.
// Reset clears pointers, occupancy, totals and the handshake; entry memories are not cleared.
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer_core
// Circular log of sequence/payload entries that overwrites the oldest entry when full.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_log_buffer_core #(
   parameter int DEPTH        = orlb_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = orlb_pkg::PAYLOAD_BITS_DEF,
   localparam int PTR_W       = $clog2(DEPTH),
   localparam int OCC_W       = $clog2(DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [orlb_pkg::ACTION_W-1:0] req_action,
   input  wire logic [orlb_pkg::SEQ_W-1:0]   req_entry_sequence,
   input  wire logic [PAYLOAD_BITS-1:0]      req_entry_payload,
   input  wire logic [orlb_pkg::SEQ_W-1:0]   req_cursor,

   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_status,
   output logic [orlb_pkg::SEQ_W-1:0]        rsp_found_sequence,
   output logic [PAYLOAD_BITS-1:0]           rsp_found_payload,
   output logic [orlb_pkg::SEQ_W-1:0]        rsp_cursor_out,
   output logic                              rsp_data_ready,
   output logic [orlb_pkg::SEQ_W-1:0]        rsp_oldest_sequence,
   output logic [OCC_W-1:0]                  rsp_used_count,
   output logic                              rsp_is_full,
   output logic [orlb_pkg::TOTAL_W-1:0]      rsp_written_total,
   output logic [orlb_pkg::TOTAL_W-1:0]      rsp_dropped_total
);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // entry memories
   logic [orlb_pkg::SEQ_W-1:0]  seq_mem_ff [DEPTH];
   logic [PAYLOAD_BITS-1:0]     pay_mem_ff [DEPTH];
   logic [orlb_pkg::SEQ_W-1:0]  seq_q_ff;
   logic [PAYLOAD_BITS-1:0]     pay_q_ff;
   logic                        mem_we;
   logic                        mem_re;
   logic [PTR_W-1:0]            rd_addr;

   // control
   orlb_pkg::state_type         state_ff, state_in;
   logic [PTR_W-1:0]            wp_ff, wp_in;
   logic [PTR_W-1:0]            rp_ff, rp_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;
   logic [orlb_pkg::TOTAL_W-1:0] pushes_ff, pushes_in;
   logic [orlb_pkg::TOTAL_W-1:0] lost_ff, lost_in;
   logic [PTR_W-1:0]            walk_pos_ff, walk_pos_in;
   logic [OCC_W-1:0]            walk_cnt_ff, walk_cnt_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // request and work registers
   orlb_pkg::action_type        act_ff, act_in;
   logic [orlb_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic [PAYLOAD_BITS-1:0]     pay_ff, pay_in;
   logic [orlb_pkg::SEQ_W-1:0]  cur_ff, cur_in;
   logic                        status_ff, status_in;
   logic [orlb_pkg::SEQ_W-1:0]  fseq_ff, fseq_in;
   logic [PAYLOAD_BITS-1:0]     fpay_ff, fpay_in;
   logic [orlb_pkg::SEQ_W-1:0]  cout_ff, cout_in;
   logic                        dready_ff, dready_in;

   // result registers
   logic                        o_status_ff, o_status_in;
   logic [orlb_pkg::SEQ_W-1:0]  o_fseq_ff, o_fseq_in;
   logic [PAYLOAD_BITS-1:0]     o_fpay_ff, o_fpay_in;
   logic [orlb_pkg::SEQ_W-1:0]  o_cout_ff, o_cout_in;
   logic                        o_dready_ff, o_dready_in;
   logic [orlb_pkg::SEQ_W-1:0]  o_oldest_ff, o_oldest_in;
   logic [OCC_W-1:0]            o_used_ff, o_used_in;
   logic                        o_full_ff, o_full_in;
   logic [orlb_pkg::TOTAL_W-1:0] o_written_ff, o_written_in;
   logic [orlb_pkg::TOTAL_W-1:0] o_dropped_ff, o_dropped_in;

   logic walk_hit;
   logic walk_miss;
   logic out_free;
   logic occ_zero;

   assign walk_hit  = rd_vld_ff && (seq_q_ff >= cur_ff);
   assign walk_miss = !rd_vld_ff && (walk_cnt_ff == occ_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign occ_zero  = (occ_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         orlb_pkg::ST_IDLE: begin
            if (req_valid) state_in = orlb_pkg::ST_EXEC;
         end
         orlb_pkg::ST_EXEC: begin
            if (act_ff == orlb_pkg::ACT_SEEK || act_ff == orlb_pkg::ACT_PROBE) begin
               state_in = orlb_pkg::ST_WALK;
            end else begin
               state_in = orlb_pkg::ST_OLD_RD;
            end
         end
         orlb_pkg::ST_WALK: begin
            if (walk_hit || walk_miss) state_in = orlb_pkg::ST_OLD_RD;
         end
         orlb_pkg::ST_OLD_RD: begin
            state_in = orlb_pkg::ST_DONE;
         end
         orlb_pkg::ST_DONE: begin
            if (out_free) state_in = orlb_pkg::ST_IDLE;
         end
         default: begin
            state_in = orlb_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = (state_ff == orlb_pkg::ST_IDLE);
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rd_addr      = rp_ff;
      rd_vld_in    = 1'b0;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      occ_in       = occ_ff;
      pushes_in    = pushes_ff;
      lost_in      = lost_ff;
      walk_pos_in  = walk_pos_ff;
      walk_cnt_in  = walk_cnt_ff;
      act_in       = act_ff;
      seq_in       = seq_ff;
      pay_in       = pay_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      fseq_in      = fseq_ff;
      fpay_in      = fpay_ff;
      cout_in      = cout_ff;
      dready_in    = dready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_status_in  = o_status_ff;
      o_fseq_in    = o_fseq_ff;
      o_fpay_in    = o_fpay_ff;
      o_cout_in    = o_cout_ff;
      o_dready_in  = o_dready_ff;
      o_oldest_in  = o_oldest_ff;
      o_used_in    = o_used_ff;
      o_full_in    = o_full_ff;
      o_written_in = o_written_ff;
      o_dropped_in = o_dropped_ff;

      unique case (state_ff)
         orlb_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in = orlb_pkg::action_type'(req_action);
               seq_in = req_entry_sequence;
               pay_in = req_entry_payload;
               cur_in = req_cursor;
            end
         end
         orlb_pkg::ST_EXEC: begin
            status_in   = 1'b0;
            fseq_in     = '0;
            fpay_in     = '0;
            cout_in     = '0;
            dready_in   = 1'b0;
            walk_pos_in = rp_ff;
            walk_cnt_in = '0;
            unique case (act_ff)
               orlb_pkg::ACT_PUSH: begin
                  mem_we = 1'b1;
                  wp_in  = ptr_next(wp_ff);
                  if (pushes_ff != '1) pushes_in = pushes_ff + 1'b1;
                  if (occ_ff == OCC_W'(DEPTH)) begin
                     rp_in = ptr_next(rp_ff);
                     if (lost_ff != '1) lost_in = lost_ff + 1'b1;
                  end else begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
               orlb_pkg::ACT_POP: begin
                  if (occ_zero) begin
                     status_in = 1'b1;
                  end else begin
                     rp_in  = ptr_next(rp_ff);
                     occ_in = occ_ff - 1'b1;
                  end
               end
               orlb_pkg::ACT_PEEK: begin
                  status_in = occ_zero;
               end
               orlb_pkg::ACT_SEEK: begin
                  cout_in = cur_ff;
               end
               orlb_pkg::ACT_PROBE: begin
                  dready_in = 1'b0;
               end
               orlb_pkg::ACT_CLEAR: begin
                  wp_in  = '0;
                  rp_in  = '0;
                  occ_in = '0;
               end
               default: begin
                  status_in = 1'b0;
               end
            endcase
         end
         orlb_pkg::ST_WALK: begin
            priority if (walk_hit) begin
               if (act_ff == orlb_pkg::ACT_SEEK) begin
                  fseq_in = seq_q_ff;
                  fpay_in = pay_q_ff;
                  cout_in = seq_q_ff;
               end else begin
                  dready_in = 1'b1;
               end
            end else if (walk_miss) begin
               status_in = 1'b1;
            end else if (walk_cnt_ff != occ_ff) begin
               mem_re      = 1'b1;
               rd_addr     = walk_pos_ff;
               rd_vld_in   = 1'b1;
               walk_pos_in = ptr_next(walk_pos_ff);
               walk_cnt_in = walk_cnt_ff + 1'b1;
            end else begin
               rd_vld_in = 1'b0;
            end
         end
         orlb_pkg::ST_OLD_RD: begin
            mem_re  = 1'b1;
            rd_addr = rp_ff;
         end
         orlb_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_status_in  = status_ff;
               o_cout_in    = cout_ff;
               o_dready_in  = dready_ff;
               if (act_ff == orlb_pkg::ACT_PEEK && !occ_zero) begin
                  o_fseq_in = seq_q_ff;
                  o_fpay_in = pay_q_ff;
               end else begin
                  o_fseq_in = fseq_ff;
                  o_fpay_in = fpay_ff;
               end
               o_oldest_in  = occ_zero ? '0 : seq_q_ff;
               o_used_in    = occ_ff;
               o_full_in    = (occ_ff == OCC_W'(DEPTH));
               o_written_in = pushes_ff;
               o_dropped_in = lost_ff;
            end
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seq_mem_ff[wp_ff] <= seq_ff;
         pay_mem_ff[wp_ff] <= pay_ff;
      end
      if (mem_re) begin
         seq_q_ff <= seq_mem_ff[rd_addr];
         pay_q_ff <= pay_mem_ff[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= orlb_pkg::ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         occ_ff       <= '0;
         pushes_ff    <= '0;
         lost_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         occ_ff       <= occ_in;
         pushes_ff    <= pushes_in;
         lost_ff      <= lost_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_pos_ff  <= walk_pos_in;
      walk_cnt_ff  <= walk_cnt_in;
      act_ff       <= act_in;
      seq_ff       <= seq_in;
      pay_ff       <= pay_in;
      cur_ff       <= cur_in;
      status_ff    <= status_in;
      fseq_ff      <= fseq_in;
      fpay_ff      <= fpay_in;
      cout_ff      <= cout_in;
      dready_ff    <= dready_in;
      o_status_ff  <= o_status_in;
      o_fseq_ff    <= o_fseq_in;
      o_fpay_ff    <= o_fpay_in;
      o_cout_ff    <= o_cout_in;
      o_dready_ff  <= o_dready_in;
      o_oldest_ff  <= o_oldest_in;
      o_used_ff    <= o_used_in;
      o_full_ff    <= o_full_in;
      o_written_ff <= o_written_in;
      o_dropped_ff <= o_dropped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = o_status_ff;
   assign rsp_found_sequence  = o_fseq_ff;
   assign rsp_found_payload   = o_fpay_ff;
   assign rsp_cursor_out      = o_cout_ff;
   assign rsp_data_ready      = o_dready_ff;
   assign rsp_oldest_sequence = o_oldest_ff;
   assign rsp_used_count      = o_used_ff;
   assign rsp_is_full         = o_full_ff;
   assign rsp_written_total   = o_written_ff;
   assign rsp_dropped_total   = o_dropped_ff;

endmodule

`default_nettype wire
